### hdl/plob_pkg.sv
package plob_pkg;

    localparam int LEVELS  = 256;
    localparam int DEPTH   = 16;
    localparam int PRICE_W = 8;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int ID_W    = 16;
    localparam int TOTAL_W = 9;
    localparam int STORE_W = PRICE_W + SLOT_W;
    localparam int META_W  = SLOT_W + CNT_W;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_LEVEL  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NO_ACTIVE = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_PEEK  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    order_id;
        logic               active;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               order_found;
        logic [ID_W-1:0]    found_id;
        logic [PRICE_W-1:0] best_ask;
        logic               ask_valid;
        logic [PRICE_W-1:0] best_bid;
        logic               bid_valid;
        logic [TOTAL_W-1:0] level_total;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    order_id;
        logic               active;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        cmd_t               cmd;
    } cmd_chan_t;

    typedef struct packed {
        logic [PRICE_W-1:0] ask;
        logic               ask_valid;
        logic [PRICE_W-1:0] bid;
        logic               bid_valid;
    } best_t;

endpackage

### hdl/plob_front.sv
module plob_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  plob_pkg::item_t     item,
    output plob_pkg::cmd_chan_t chan,
    input  logic                pop
);

    // Two-entry queue of classified commands.
    plob_pkg::cmd_t ent_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    logic           do_pop;
    plob_pkg::cmd_t cmd_in;

    assign busy   = (cnt_reg == 2'd2);
    assign push   = start && !busy;
    assign do_pop = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        cmd_in.op       = plob_pkg::op_t'(item.mode);
        cmd_in.price    = item.price;
        cmd_in.order_id = item.order_id;
        cmd_in.active   = item.active;
        chan.valid      = (cnt_reg != 2'd0);
        chan.cmd        = ent_reg[rd_ptr_reg];
        wr_ptr_next     = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next     = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next        = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### hdl/plob_best.sv
module plob_best
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [plob_pkg::LEVELS-1:0]    occ,
    output plob_pkg::best_t                best
);

    typedef struct packed {
        logic       any;
        logic [2:0] lo;
        logic [2:0] hi;
    } enc_t;

    function automatic enc_t enc8(input logic [7:0] m);
        enc_t e;
        e.any = |m;
        e.lo  = 3'd0;
        e.hi  = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (m[i]) e.lo = 3'(i);
        end
        for (int i = 0; i < 8; i++)
        begin
            if (m[i]) e.hi = 3'(i);
        end
        return e;
    endfunction

    logic [31:0]     any1_reg;
    logic [2:0]      lo1_reg [32];
    logic [2:0]      hi1_reg [32];
    logic [3:0]      any2_reg;
    logic [5:0]      lo2_reg [4];
    logic [5:0]      hi2_reg [4];
    plob_pkg::best_t best_reg, best_next;

    assign best = best_reg;

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 32; g++)
        begin
            enc_t e;
            e           = enc8(occ[g*8 +: 8]);
            any1_reg[g] <= e.any;
            lo1_reg[g]  <= e.lo;
            hi1_reg[g]  <= e.hi;
        end
        for (int s = 0; s < 4; s++)
        begin
            enc_t e;
            e           = enc8(any1_reg[s*8 +: 8]);
            any2_reg[s] <= e.any;
            lo2_reg[s]  <= {e.lo, lo1_reg[{2'(s), e.lo}]};
            hi2_reg[s]  <= {e.hi, hi1_reg[{2'(s), e.hi}]};
        end
    end

    always_comb
    begin
        best_next = '0;
        for (int j = 3; j >= 0; j--)
        begin
            if (any2_reg[j])
            begin
                best_next.ask       = {2'(j), lo2_reg[j]};
                best_next.ask_valid = 1'b1;
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            if (any2_reg[j])
            begin
                best_next.bid       = {2'(j), hi2_reg[j]};
                best_next.bid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

endmodule

### hdl/plob_back.sv
module plob_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  plob_pkg::cmd_chan_t chan,
    output logic                pop,
    output logic                done,
    output plob_pkg::result_t   result
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_META = 7'b000_0010,
        S_PEEK = 7'b000_0100,
        S_W1   = 7'b000_1000,
        S_W2   = 7'b001_0000,
        S_W3   = 7'b010_0000,
        S_EMIT = 7'b100_0000
    } state_t;

    state_t                            state_reg, state_next;
    plob_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [plob_pkg::SLOT_W-1:0]       head_reg, head_next;
    logic [plob_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [1:0]                        status_reg, status_next;
    logic                              found_reg, found_next;
    logic [plob_pkg::ID_W-1:0]         fid_reg, fid_next;
    logic [plob_pkg::LEVELS-1:0]       occ_reg, occ_next;
    logic [plob_pkg::TOTAL_W-1:0]      total_reg, total_next;
    logic [plob_pkg::LEVELS-1:0]       mvld_reg, mvld_next;
    logic                              mvld_q_reg;
    plob_pkg::result_t                 result_reg, result_next;
    logic                              done_reg, done_next;

    // Per-level head and count, and the order slots.
    logic [plob_pkg::META_W-1:0]       meta_mem [plob_pkg::LEVELS];
    logic [plob_pkg::META_W-1:0]       meta_rdata_reg;
    logic                              meta_we;
    logic [plob_pkg::META_W-1:0]       meta_wdata;
    logic [plob_pkg::ID_W:0]           store_mem [plob_pkg::LEVELS*plob_pkg::DEPTH];
    logic [plob_pkg::ID_W:0]           store_rdata_reg;
    logic                              store_we;
    logic [plob_pkg::STORE_W-1:0]      store_waddr;
    logic [plob_pkg::STORE_W-1:0]      store_raddr;

    plob_pkg::best_t                   best;
    logic [plob_pkg::SLOT_W-1:0]       cur_head;
    logic [plob_pkg::CNT_W-1:0]        cur_count;
    logic [plob_pkg::CNT_W-1:0]        dec_count;

    plob_best u_best
    (
        .clk   (clk),
        .rst_n (rst_n),
        .occ   (occ_reg),
        .best  (best)
    );

    assign pop    = (state_reg == S_IDLE) && chan.valid;
    assign done   = done_reg;
    assign result = result_reg;

    assign cur_head  = mvld_q_reg ? meta_rdata_reg[plob_pkg::META_W-1 -: plob_pkg::SLOT_W]
                                  : '0;
    assign cur_count = mvld_q_reg ? meta_rdata_reg[plob_pkg::CNT_W-1:0] : '0;
    assign dec_count = count_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        found_next  = found_reg;
        fid_next    = fid_reg;
        occ_next    = occ_reg;
        total_next  = total_reg;
        mvld_next   = mvld_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        meta_we     = 1'b0;
        meta_wdata  = '0;
        store_we    = 1'b0;
        store_waddr = {cmd_reg.price, cur_head + cur_count[plob_pkg::SLOT_W-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (chan.valid)
                begin
                    cmd_next    = chan.cmd;
                    status_next = plob_pkg::ST_OK;
                    found_next  = 1'b0;
                    fid_next    = '0;
                    state_next  = S_META;
                end
            end
            S_META:
            begin
                state_next = S_W1;
                head_next  = cur_head;
                count_next = cur_count;
                case (cmd_reg.op)
                    plob_pkg::OP_ADD:
                    begin
                        if (cur_count == plob_pkg::CNT_W'(plob_pkg::DEPTH))
                        begin
                            status_next = plob_pkg::ST_FULL;
                        end
                        else
                        begin
                            store_we   = 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata = {cur_head, cur_count + 1'b1};
                            if (!occ_reg[cmd_reg.price])
                            begin
                                occ_next[cmd_reg.price] = 1'b1;
                                total_next = total_reg + 1'b1;
                            end
                        end
                    end
                    plob_pkg::OP_POP:
                    begin
                        if (cur_count == '0)
                        begin
                            status_next = plob_pkg::ST_NO_LEVEL;
                        end
                        else
                        begin
                            meta_we = 1'b1;
                            if (cur_count == plob_pkg::CNT_W'(1))
                            begin
                                meta_wdata = '0;
                                occ_next[cmd_reg.price] = 1'b0;
                                total_next = total_reg - 1'b1;
                            end
                            else
                            begin
                                meta_wdata = {cur_head + 1'b1, cur_count - 1'b1};
                            end
                        end
                    end
                    plob_pkg::OP_CLEAR:
                    begin
                        if (cur_count == '0)
                        begin
                            status_next = plob_pkg::ST_NO_LEVEL;
                        end
                        else
                        begin
                            meta_we    = 1'b1;
                            meta_wdata = '0;
                            occ_next[cmd_reg.price] = 1'b0;
                            total_next = total_reg - 1'b1;
                        end
                    end
                    plob_pkg::OP_PEEK:
                    begin
                        if (cur_count == '0)
                        begin
                            status_next = plob_pkg::ST_NO_LEVEL;
                        end
                        else
                        begin
                            status_next = plob_pkg::ST_NO_ACTIVE;
                            state_next  = S_PEEK;
                        end
                    end
                    default:
                    begin
                        status_next = plob_pkg::ST_NO_LEVEL;
                    end
                endcase
            end
            S_PEEK:
            begin
                // The slot at head_reg was read in the previous cycle.
                if (store_rdata_reg[plob_pkg::ID_W])
                begin
                    status_next = plob_pkg::ST_OK;
                    found_next  = 1'b1;
                    fid_next    = store_rdata_reg[plob_pkg::ID_W-1:0];
                    meta_we     = 1'b1;
                    meta_wdata  = {head_reg, count_reg};
                    state_next  = S_W1;
                end
                else if (dec_count == '0)
                begin
                    meta_we    = 1'b1;
                    meta_wdata = '0;
                    count_next = '0;
                    head_next  = '0;
                    occ_next[cmd_reg.price] = 1'b0;
                    total_next = total_reg - 1'b1;
                    state_next = S_W1;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    count_next = dec_count;
                end
            end
            S_W1:
            begin
                state_next = S_W2;
            end
            S_W2:
            begin
                state_next = S_W3;
            end
            S_W3:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                result_next.status      = status_reg;
                result_next.order_found = found_reg;
                result_next.found_id    = fid_reg;
                result_next.best_ask    = best.ask;
                result_next.ask_valid   = best.ask_valid;
                result_next.best_bid    = best.bid;
                result_next.bid_valid   = best.bid_valid;
                result_next.level_total = total_reg;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (meta_we)
        begin
            mvld_next[cmd_reg.price] = 1'b1;
        end
        store_raddr = {cmd_reg.price, head_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            total_reg <= '0;
            mvld_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            total_reg <= total_next;
            mvld_reg  <= mvld_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        head_reg   <= head_next;
        count_reg  <= count_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        fid_reg    <= fid_next;
        result_reg <= result_next;
        mvld_q_reg <= mvld_reg[chan.cmd.price];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[cmd_reg.price] <= meta_wdata;
        end
        meta_rdata_reg <= meta_mem[chan.cmd.price];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= {cmd_reg.active, cmd_reg.order_id};
        end
        store_rdata_reg <= store_mem[store_raddr];
    end

endmodule

### hdl/price_level_order_book.sv
// Price-level order book: one first-in first-out queue of order handles per
// price level, with a map of which levels are occupied.
// An item is accepted at a rising edge where start is high and busy is low.
// Its fields are mode (add, pop front, clear level, peek active front),
// price, order_id and active. Each item yields exactly one result, shown on
// result for one cycle while done is high; the receiver cannot hold it off.
// A front queue of two items takes items while the engine works, so busy
// rises only when both entries are waiting.
// The engine takes an item from the queue, reads the level's head and count
// from memory, then updates the queue. A peek walks the level one slot per
// cycle, discarding cancelled orders until it finds an active one or the
// level is empty. The best ask and best bid come from a three-stage
// registered search over the occupancy map. The engine steps through its
// idle, meta, W1, W2, W3 and emit states, with peek steps after meta, so the
// best prices in each result include that item's own update; it takes no
// new item from the queue until it has emitted the last result.
// Reset clears the occupancy map, the level total and the per-level valid
// bits, so every level reads as empty; no clearing pass is needed and the
// block can accept an item as soon as reset is released.
module price_level_order_book
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  plob_pkg::item_t   item,
    output logic              done,
    output plob_pkg::result_t result
);

    plob_pkg::cmd_chan_t chan;
    logic                pop;

    plob_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .chan  (chan),
        .pop   (pop)
    );

    plob_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chan   (chan),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

### tb/sv/tb_price_level_order_book.sv
module tb_price_level_order_book;

    // The book keeps at most sixteen orders per level, which is enough to be
    // a fair image of the block: its own copy of head, count and slot store.
    class book_scoreboard;
        logic [plob_pkg::ID_W:0] slots [plob_pkg::LEVELS][plob_pkg::DEPTH];
        int unsigned        head [plob_pkg::LEVELS];
        int unsigned        count [plob_pkg::LEVELS];
        int unsigned        occupied_levels;
        plob_pkg::result_t  pending [$];
        int                 errors;

        function new();
            for (int p = 0; p < plob_pkg::LEVELS; p++)
            begin
                head[p] = 0;
                count[p] = 0;
            end
            occupied_levels = 0;
            errors = 0;
        endfunction

        function void drop_front(int p);
            head[p] = (head[p] + 1) % plob_pkg::DEPTH;
            count[p]--;
            if (count[p] == 0)
            begin
                head[p] = 0;
                occupied_levels--;
            end
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_item(plob_pkg::item_t it);
            plob_pkg::result_t r;
            int p;
            r = '0;
            p = int'(it.price);
            case (plob_pkg::op_t'(it.mode))
                plob_pkg::OP_ADD:
                    if (count[p] >= plob_pkg::DEPTH)
                        r.status = plob_pkg::ST_FULL;
                    else
                    begin
                        slots[p][(head[p] + count[p]) % plob_pkg::DEPTH] =
                            {it.active, it.order_id};
                        if (count[p] == 0)
                            occupied_levels++;
                        count[p]++;
                    end
                plob_pkg::OP_POP:
                    if (count[p] == 0)
                        r.status = plob_pkg::ST_NO_LEVEL;
                    else
                        drop_front(p);
                plob_pkg::OP_CLEAR:
                    if (count[p] == 0)
                        r.status = plob_pkg::ST_NO_LEVEL;
                    else
                    begin
                        head[p] = 0;
                        count[p] = 0;
                        occupied_levels--;
                    end
                default:
                    if (count[p] == 0)
                        r.status = plob_pkg::ST_NO_LEVEL;
                    else
                    begin
                        r.status = plob_pkg::ST_NO_ACTIVE;
                        while (count[p] != 0)
                        begin
                            if (slots[p][head[p]][plob_pkg::ID_W])
                            begin
                                r.status = plob_pkg::ST_OK;
                                r.order_found = 1'b1;
                                r.found_id = slots[p][head[p]][plob_pkg::ID_W-1:0];
                                break;
                            end
                            drop_front(p);
                        end
                    end
            endcase
            for (int i = 0; i < plob_pkg::LEVELS; i++)
                if (count[i] != 0)
                begin
                    if (!r.ask_valid)
                    begin
                        r.best_ask = 8'(i);
                        r.ask_valid = 1'b1;
                    end
                    r.best_bid = 8'(i);
                    r.bid_valid = 1'b1;
                end
            r.level_total = 9'(occupied_levels);
            pending.insert(pending.size(), r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(plob_pkg::result_t got);
            plob_pkg::result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", 32'(got.status), 32'd0);
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.order_found !== want.order_found)
                report("order_found", 32'(got.order_found), 32'(want.order_found));
            if (got.found_id !== want.found_id)
                report("found_id", 32'(got.found_id), 32'(want.found_id));
            if (got.best_ask !== want.best_ask)
                report("best_ask", 32'(got.best_ask), 32'(want.best_ask));
            if (got.ask_valid !== want.ask_valid)
                report("ask_valid", 32'(got.ask_valid), 32'(want.ask_valid));
            if (got.best_bid !== want.best_bid)
                report("best_bid", 32'(got.best_bid), 32'(want.best_bid));
            if (got.bid_valid !== want.bid_valid)
                report("bid_valid", 32'(got.bid_valid), 32'(want.bid_valid));
            if (got.level_total !== want.level_total)
                report("level_total", 32'(got.level_total), 32'(want.level_total));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    plob_pkg::item_t   item;
    logic              done;
    plob_pkg::result_t result;

    book_scoreboard book;
    int      idle_pct;
    int      quiet_cycles = 0;
    bit      timed_out;

    price_level_order_book dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle; the watchdog counts edges where nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                book.check_result(result);
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one item, with random gaps ahead of it, and holds start until
    // the block takes it. Start is only lowered once no item follows at once.
    task automatic send_item(plob_pkg::item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        book.note_item(it);
    endtask

    task automatic send_op(plob_pkg::op_t op, int price, int id, bit act);
        plob_pkg::item_t it;
        it.mode = op;
        it.price = 8'(price);
        it.order_id = 16'(id);
        it.active = act;
        send_item(it);
    endtask

    // Random traffic crowded onto a few levels so that queues fill, peeks
    // discard cancelled orders and the best prices keep moving.
    task automatic random_phase(int n);
        int hot;
        int p;
        int pick;
        plob_pkg::op_t op;
        for (int k = 0; k < n; k++)
        begin
            hot = $urandom_range(7);
            pick = $urandom_range(99);
            p = ($urandom_range(9) < 8) ? (hot * 36 + $urandom_range(2)) : $urandom_range(255);
            if (pick < 50) op = plob_pkg::OP_ADD;
            else if (pick < 70) op = plob_pkg::OP_POP;
            else if (pick < 77) op = plob_pkg::OP_CLEAR;
            else op = plob_pkg::OP_PEEK;
            send_op(op, p, $urandom_range(65535), $urandom_range(2) != 0);
        end
    endtask

    initial
    begin
        book = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        idle_pct = 0;
        timed_out = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            begin
                // Directed part: empty levels, both extreme prices, a full
                // level, a peek past cancelled orders and one finding none.
                send_op(plob_pkg::OP_POP, 0, 0, 0);
                send_op(plob_pkg::OP_CLEAR, 255, 0, 0);
                send_op(plob_pkg::OP_PEEK, 128, 0, 1);
                send_op(plob_pkg::OP_ADD, 0, 16'hFFFF, 1);
                send_op(plob_pkg::OP_ADD, 255, 16'h0000, 0);
                for (int k = 0; k < 16; k++)
                    send_op(plob_pkg::OP_ADD, 100, 16'h5A00 + k, k >= 3);
                send_op(plob_pkg::OP_ADD, 100, 16'hAAAA, 1);
                send_op(plob_pkg::OP_PEEK, 100, 0, 0);
                send_op(plob_pkg::OP_POP, 100, 0, 0);
                send_op(plob_pkg::OP_PEEK, 255, 0, 0);
                send_op(plob_pkg::OP_CLEAR, 100, 0, 0);
                send_op(plob_pkg::OP_POP, 0, 0, 0);
                idle_pct = 30;
                random_phase(475);
                idle_pct = 88;
                random_phase(475);
                idle_pct = 0;
                random_phase(475);
                start <= 1'b0;
                while (book.pending.size() != 0)
                    @(posedge clk);
                repeat (40) @(posedge clk);
            end
            begin
                while (quiet_cycles < 2000)
                    @(posedge clk);
                timed_out = 1;
            end
        join_any

        if (timed_out)
            $display("DONE: errors detected");
        else if (book.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
